// ===== hdl/twls_pkg.sv =====
// Shared constants, types and helpers for the typed window load/store block.
package twls_pkg;

   localparam int BUF_BYTES = 4096;
   localparam int LANES     = 8;
   localparam int ROWS      = (BUF_BYTES + LANES - 1) / LANES;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW        = $clog2(BUF_BYTES);
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] VIEW_LENGTH_RST = CFG_W'(4096);
   localparam logic [63:0]      S64_SAT_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] REG_VIEW_OFFSET = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_LENGTH = CSR_IDX_W'(1);

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [3:0] {
      KIND_I8  = 4'd0,
      KIND_U8  = 4'd1,
      KIND_I16 = 4'd2,
      KIND_U16 = 4'd3,
      KIND_I32 = 4'd4,
      KIND_U32 = 4'd5,
      KIND_F32 = 4'd6,
      KIND_F64 = 4'd7,
      KIND_I64 = 4'd8,
      KIND_U64 = 4'd9
   } kind_type;

   // control carried alongside the bank read data
   typedef struct packed {
      logic       ok;
      logic       op;
      kind_type   kind;
      logic       le;
      logic [3:0] size;
      logic [2:0] lane0;
   } stage_type;

   // access size in bytes, 0 for unused kinds
   function automatic logic [3:0] kind_size(input logic [3:0] kind);
      logic [3:0] sz;
      case (kind)
         KIND_I8, KIND_U8:             sz = 4'd1;
         KIND_I16, KIND_U16:           sz = 4'd2;
         KIND_I32, KIND_U32, KIND_F32: sz = 4'd4;
         KIND_F64, KIND_I64, KIND_U64: sz = 4'd8;
         default:                      sz = 4'd0;
      endcase
      return sz;
   endfunction

endpackage

// ===== hdl/twls_req_if.sv =====
// Request channel: one typed load or store item.
interface twls_req_if import twls_pkg::*;;
   logic               valid;
   logic               ready;
   logic               op;
   logic [3:0]         kind;
   logic signed [31:0] byte_offset;
   logic               little_endian;
   logic [63:0]        write_value;

   modport source (output valid, op, kind, byte_offset, little_endian, write_value,
                   input ready);
   modport sink   (input valid, op, kind, byte_offset, little_endian, write_value,
                   output ready);
endinterface

// ===== hdl/twls_rsp_if.sv =====
// Response channel: status and read data for one item.
interface twls_rsp_if import twls_pkg::*;;
   logic               valid;
   logic               ready;
   logic               ok;
   logic signed [63:0] read_value;

   modport source (output valid, ok, read_value, input ready);
   modport sink   (input valid, ok, read_value, output ready);
endinterface

// ===== hdl/twls_csr_if.sv =====
// Register write channel: index and write data.
interface twls_csr_if import twls_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== hdl/typed_window_load_store.sv =====
// Top level: typed endian load/store through a window onto a banked byte store.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------------
//   csr_ch   | in  | valid/ready  | index, wdata (view_offset, view_length)
//   req_ch   | in  | valid/ready  | op, kind, byte_offset, little_endian,
//            |     |              | write_value
//   rsp_ch   | out | valid/ready  | ok, read_value
//
// Takes one item per cycle while rsp_ch is not stalled. The taking edge loads
// the bank read and the read stage; the output register loads once it is free.
// After reset the store is zeroed one row (8 bytes) per cycle, over all ROWS rows
// (512 here); req_ch.ready stays low until then, csr_ch always ready.
// A stalled rsp_ch backs up into the read stage, then drops req_ch.ready.
module typed_window_load_store import twls_pkg::*; (
   input logic         clock,
   input logic         reset,
   twls_csr_if.sink    csr_ch,
   twls_req_if.sink    req_ch,
   twls_rsp_if.source  rsp_ch
);

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] clr_row_ff, clr_row_in;

   logic [CFG_W-1:0] view_offset_ff, view_offset_in;
   logic [CFG_W-1:0] view_length_ff, view_length_in;

   logic        s1_valid_ff, s1_valid_in;
   stage_type   s1_ff, s1_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [63:0] rsp_value_ff, rsp_value_in;

   // ---------------- config registers ----------------
   logic csr_wr;
   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid & csr_ch.ready;

   always_comb begin
      view_offset_in = view_offset_ff;
      view_length_in = view_length_ff;
      if (csr_wr) begin
         case (csr_ch.index)
            REG_VIEW_OFFSET: view_offset_in = csr_ch.wdata;
            REG_VIEW_LENGTH: view_length_in = csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   logic out_free, s1_adv, req_acc;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = (state_ff == ST_RUN) && (!s1_valid_ff || out_free);
   assign req_acc      = req_ch.valid && req_ch.ready;

   // ---------------- window check and address ----------------
   logic [3:0]       size;
   logic [32:0]      win_end, win_sum, abs_addr, acc_end;
   logic             acc_ok;
   logic [AW-1:0]    addr;
   logic [2:0]       lane0;
   logic [ROW_W-1:0] row_lo, row_hi;

   always_comb begin
      size     = kind_size(req_ch.kind);
      win_sum  = 33'(view_offset_ff) + 33'(view_length_ff);
      // end of window clamps to the end of the store
      win_end  = (win_sum > 33'(BUF_BYTES)) ? 33'(BUF_BYTES) : win_sum;
      abs_addr = 33'(view_offset_ff) + 33'(req_ch.byte_offset[30:0]);
      acc_end  = abs_addr + 33'(size);
      // negative offset, unused kind or past the window: no write, ok low, zero data
      acc_ok   = (size != 4'd0) && !req_ch.byte_offset[31] && (acc_end <= win_end);
      addr     = abs_addr[AW-1:0];
      lane0    = 3'(addr);
      row_lo   = ROW_W'(addr >> 3);
      // an unaligned access spills into the next row on the low lanes
      row_hi   = (row_lo == ROW_W'(ROWS - 1)) ? row_lo : row_lo + 1'b1;
   end

   // ---------------- per-lane steering ----------------
   // byte i of the access sits in lane (lane0 + i) mod 8
   logic [ROW_W-1:0] lane_row [LANES];
   logic             lane_we  [LANES];
   logic [7:0]       lane_wd  [LANES];
   logic [7:0]       lane_rd  [LANES];

   always_comb begin
      logic [2:0] idx;
      logic [2:0] k;
      for (int j = 0; j < LANES; j++) begin
         idx = 3'(j) - lane0;
         k   = req_ch.little_endian ? idx : 3'(size - 4'd1 - {1'b0, idx});
         if (state_ff == ST_CLEAR) begin
            lane_row[j] = clr_row_ff;
            lane_we[j]  = 1'b1;
            lane_wd[j]  = 8'h00;
         end else begin
            lane_row[j] = (3'(j) >= lane0) ? row_lo : row_hi;
            lane_we[j]  = req_acc && acc_ok && (req_ch.op == OP_WRITE) &&
                          ({1'b0, idx} < size);
            lane_wd[j]  = req_ch.write_value[8*k +: 8];
         end
      end
   end

   // ---------------- byte banks ----------------
   for (genvar j = 0; j < LANES; j++) begin : g_bank
      logic [7:0] mem [ROWS];
      logic [7:0] rd_ff;

      always_ff @(posedge clock) begin
         if (lane_we[j]) begin
            mem[lane_row[j]] <= lane_wd[j];
         end
         if (req_acc) begin
            rd_ff <= mem[lane_row[j]];
         end
      end

      assign lane_rd[j] = rd_ff;
   end

   // ---------------- read stage ----------------
   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
         s1_in.ok    = acc_ok;
         s1_in.op    = req_ch.op;
         s1_in.kind  = kind_type'(req_ch.kind);
         s1_in.le    = req_ch.little_endian;
         s1_in.size  = size;
         s1_in.lane0 = lane0;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- assemble and extend ----------------
   logic [63:0] raw, ext;

   always_comb begin
      logic [2:0] i;
      logic [2:0] lane;
      for (int k = 0; k < LANES; k++) begin
         i    = s1_ff.le ? 3'(k) : 3'(s1_ff.size - 4'd1 - 4'(k));
         lane = s1_ff.lane0 + i;
         raw[8*k +: 8] = (4'(k) < s1_ff.size) ? lane_rd[lane] : 8'h00;
      end
      case (s1_ff.kind)
         KIND_I8:  ext = {{56{raw[7]}}, raw[7:0]};
         KIND_I16: ext = {{48{raw[15]}}, raw[15:0]};
         KIND_I32: ext = {{32{raw[31]}}, raw[31:0]};
         KIND_U64: ext = raw[63] ? S64_SAT_LIMIT : raw;
         default:  ext = raw;
      endcase
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = s1_ff.ok;
         rsp_value_in = (s1_ff.ok && s1_ff.op == OP_READ) ? ext : 64'd0;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.ok         = rsp_ok_ff;
   assign rsp_ch.read_value = rsp_value_ff;

   // ---------------- clear sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      clr_row_in = clr_row_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: ;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_row_ff     <= '0;
         view_offset_ff <= '0;
         view_length_ff <= VIEW_LENGTH_RST;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_row_ff     <= clr_row_in;
         view_offset_ff <= view_offset_in;
         view_length_ff <= view_length_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
   end

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> (state_ff == ST_RUN))
      else $error("item taken during store clear");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && (clr_row_ff == ROW_W'(ROWS - 1)) |=> (state_ff == ST_RUN))
      else $error("clear pass did not finish");

   a_fail_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> (rsp_value_ff == 64'd0))
      else $error("failed access returned data");

   a_read_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_ff))
      else $error("read stage lost an item under stall");
`endif

endmodule
